// ----- sv/iaf_pkg.sv -----
package iaf_pkg;

    localparam int ValueWidth = 32;
    localparam int BcdDigits  = 10;
    localparam int BcdWidth   = 4 * BcdDigits;

    localparam logic [1:0] OP_SDEC = 2'd0;
    localparam logic [1:0] OP_UDEC = 2'd1;
    localparam logic [1:0] OP_LHEX = 2'd2;
    localparam logic [1:0] OP_UHEX = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LOWER = 8'h61;
    localparam logic [7:0] CH_UPPER = 8'h41;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  opcode;
        logic [5:0]  field_width;
        logic [1:0]  pad_mode;
    } item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } text_t;

endpackage

// ----- sv/iaf_bcd_conv.sv -----
module iaf_bcd_conv
    import iaf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [ValueWidth-1:0] bin,
    output logic                  done,
    output logic [BcdWidth-1:0]   bcd
);

    localparam int CntWidth = $clog2(ValueWidth);

    logic [ValueWidth-1:0] bin_reg, bin_next;
    logic [BcdWidth-1:0]   bcd_reg, bcd_next;
    logic [CntWidth-1:0]   cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [BcdWidth-1:0]   adj;

    // shift-and-add-3: correct every digit, then shift one bit in
    always_comb
    begin
        for (int i = 0; i < BcdDigits; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next = bin;
            bcd_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            bcd_next = {adj[BcdWidth-2:0], bin_reg[ValueWidth-1]};
            bin_next = {bin_reg[ValueWidth-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntWidth'(ValueWidth - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// ----- sv/integer_to_ascii_formatter_unit.sv -----
// a decimal word is converted to BCD first, a hex word is not; leading zero digits are
// then stripped (0 to 9 decimal, 2 to 9 hex); then one character per cycle unless stalled
// decimal: load, shift-and-add-3 of 32 bits, handover; then strip steps, a check, set-up
// words are taken one at a time, the next one the cycle after the last character is
// loaded; text_stall holds back the characters
// rst_n is asynchronous, active low; it empties the output register and idles
module integer_to_ascii_formatter_unit
    import iaf_pkg::*;
#(
    parameter int MAX_WIDTH = 63
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_stall,
    input  item_t item,
    output logic  text_valid,
    input  logic  text_stall,
    output text_t text
);

    localparam logic [5:0] MaxW = 6'(MAX_WIDTH);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CONV  = 4'd1;
    localparam logic [3:0] ST_TRIM  = 4'd2;
    localparam logic [3:0] ST_PREP  = 4'd3;
    localparam logic [3:0] ST_SIGN1 = 4'd4;
    localparam logic [3:0] ST_LPAD  = 4'd5;
    localparam logic [3:0] ST_SIGN2 = 4'd6;
    localparam logic [3:0] ST_DIG   = 4'd7;
    localparam logic [3:0] ST_RPAD  = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [BcdWidth-1:0] digits_reg, digits_next;
    logic [3:0]          ndig_reg, ndig_next;
    logic [5:0]          padcnt_reg, padcnt_next;
    logic [5:0]          width_reg, width_next;
    logic                left_reg, left_next;
    logic                zfill_reg, zfill_next;
    logic                upper_reg, upper_next;
    logic                sign1_reg, sign1_next;
    logic                sign2_reg, sign2_next;
    text_t               out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                  accept;
    logic                  neg;
    logic                  hex;
    logic [5:0]            wsat;
    logic [ValueWidth-1:0] mag;
    logic                  conv_start;
    logic                  conv_done;
    logic [BcdWidth-1:0]   conv_bcd;
    logic                  slot_free;
    logic [4:0]            text_len;
    logic [5:0]            prep_pad;
    logic [3:0]            top_dig;
    logic [7:0]            dig_char;
    logic [7:0]            pad_char;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign hex        = (item.opcode == OP_LHEX) || (item.opcode == OP_UHEX);
    assign neg        = (item.opcode == OP_SDEC) && item.value[ValueWidth-1];
    assign mag        = neg ? (~item.value + 1'b1) : item.value;
    assign wsat       = (item.field_width > MaxW) ? MaxW : item.field_width;
    assign conv_start = accept && !hex;

    iaf_bcd_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .bin   (mag),
        .done  (conv_done),
        .bcd   (conv_bcd)
    );

    assign slot_free = !out_valid_reg || !text_stall;
    assign text_len  = {1'b0, ndig_reg} + {4'b0, sign2_reg};
    assign prep_pad  = ({1'b0, text_len} >= width_reg) ? 6'd0
                                                        : width_reg - {1'b0, text_len};
    assign top_dig   = digits_reg[BcdWidth-1 -: 4];
    assign pad_char  = zfill_reg ? CH_ZERO : CH_SPACE;

    always_comb
    begin
        if (top_dig >= 4'd10)
            dig_char = (upper_reg ? CH_UPPER : CH_LOWER) + {4'b0, top_dig - 4'd10};
        else
            dig_char = CH_ZERO + {4'b0, top_dig};
    end

    always_comb
    begin
        state_next     = state_reg;
        digits_next    = digits_reg;
        ndig_next      = ndig_reg;
        padcnt_next    = padcnt_reg;
        width_next     = width_reg;
        left_next      = left_reg;
        zfill_next     = zfill_reg;
        upper_next     = upper_reg;
        sign1_next     = sign1_reg;
        sign2_next     = sign2_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && text_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    left_next   = item.pad_mode[0];
                    zfill_next  = item.pad_mode[1];
                    upper_next  = (item.opcode == OP_UHEX);
                    // zero fill puts the sign ahead of the padding
                    sign1_next  = neg && (wsat != 6'd0) && item.pad_mode[1];
                    sign2_next  = neg && !((wsat != 6'd0) && item.pad_mode[1]);
                    width_next  = wsat - {5'b0, neg && (wsat != 6'd0) && item.pad_mode[1]};
                    ndig_next   = 4'(BcdDigits);
                    digits_next = {{(BcdWidth-ValueWidth){1'b0}}, item.value};
                    state_next  = hex ? ST_TRIM : ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_done)
                begin
                    digits_next = conv_bcd;
                    state_next  = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                if ((top_dig == 4'd0) && (ndig_reg != 4'd1))
                begin
                    digits_next = {digits_reg[BcdWidth-5:0], 4'b0};
                    ndig_next   = ndig_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                padcnt_next = prep_pad;
                priority if (sign1_reg)
                    state_next = ST_SIGN1;
                else if (!left_reg && (prep_pad != 6'd0))
                    state_next = ST_LPAD;
                else if (sign2_reg)
                    state_next = ST_SIGN2;
                else
                    state_next = ST_DIG;
            end
            ST_SIGN1:
            begin
                if (slot_free)
                begin
                    out_next       = '{char_out: CH_MINUS, last: 1'b0};
                    out_valid_next = 1'b1;
                    if (!left_reg && (padcnt_reg != 6'd0))
                        state_next = ST_LPAD;
                    else
                        state_next = ST_DIG;
                end
            end
            ST_LPAD:
            begin
                if (slot_free)
                begin
                    out_next       = '{char_out: pad_char, last: 1'b0};
                    out_valid_next = 1'b1;
                    padcnt_next    = padcnt_reg - 1'b1;
                    if (padcnt_reg == 6'd1)
                        state_next = sign2_reg ? ST_SIGN2 : ST_DIG;
                end
            end
            ST_SIGN2:
            begin
                if (slot_free)
                begin
                    out_next       = '{char_out: CH_MINUS, last: 1'b0};
                    out_valid_next = 1'b1;
                    state_next     = ST_DIG;
                end
            end
            ST_DIG:
            begin
                if (slot_free)
                begin
                    out_next.char_out = dig_char;
                    out_next.last     = (ndig_reg == 4'd1) &&
                                        !(left_reg && (padcnt_reg != 6'd0));
                    out_valid_next    = 1'b1;
                    digits_next       = {digits_reg[BcdWidth-5:0], 4'b0};
                    ndig_next         = ndig_reg - 1'b1;
                    if (ndig_reg == 4'd1)
                        state_next = (left_reg && (padcnt_reg != 6'd0)) ? ST_RPAD : ST_IDLE;
                end
            end
            ST_RPAD:
            begin
                if (slot_free)
                begin
                    out_next       = '{char_out: pad_char, last: (padcnt_reg == 6'd1)};
                    out_valid_next = 1'b1;
                    padcnt_next    = padcnt_reg - 1'b1;
                    if (padcnt_reg == 6'd1)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        ndig_reg   <= ndig_next;
        padcnt_reg <= padcnt_next;
        width_reg  <= width_next;
        left_reg   <= left_next;
        zfill_reg  <= zfill_next;
        upper_reg  <= upper_next;
        sign1_reg  <= sign1_next;
        sign2_reg  <= sign2_next;
        out_reg    <= out_next;
    end

    assign text_valid = out_valid_reg;
    assign text       = out_reg;

endmodule
